// ===== hw/rtl/mbp_pkg.sv =====
// Shared types and constants for the MSB-first bit packer.
// Used by mbp_path_src, mbp_byte_acc and msb_first_bit_packer_core.
// No dependencies.
package mbp_pkg;

   // Field widths of the request and response channels.
   localparam int OpW        = 2;
   localparam int PathFieldW = 32;
   localparam int PathLenW   = 6;
   localparam int ByteW      = 8;
   localparam int RoomW      = 4;

   // Longest path that one request may append.
   localparam int MaxPath    = 32;
   localparam int PathLimit  = (MaxPath < PathFieldW) ? MaxPath : PathFieldW;
   localparam int BitIdxW    = $clog2(PathFieldW);

   // Request operation codes.
   typedef enum logic [OpW-1:0] {
      OP_APPEND = 2'd0,
      OP_INSERT = 2'd1,
      OP_FLUSH  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   // Sequencer states of the top level.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PATH,
      ST_INSERT,
      ST_FLUSH,
      ST_TRAIL
   } state_type;

   // Commands from the sequencer to the byte accumulator.
   typedef struct packed {
      logic push_bit;
      logic bit_val;
      logic insert;
      logic clear;
   } acc_cmd_type;

   // Byte values and flags that the accumulator offers to the sequencer.
   typedef struct packed {
      logic [ByteW-1:0] partial_byte;
      logic [ByteW-1:0] full_byte;
      logic [ByteW-1:0] insert_byte;
      logic [ByteW-1:0] trailer_byte;
      logic             empty;
      logic             one_free;
   } acc_status_type;

endpackage

// ===== hw/rtl/msb_first_bit_packer_core.sv =====
// Usage of msb_first_bit_packer_core:
// Requests arrive on req_* (valid/ready). req_operation selects append path
// (req_path_bits, req_path_len bits, max 32, sent from index len-1 to 0), insert
// byte (req_data_byte at the current alignment) or flush (partial byte if any,
// then a trailer byte with the valid bit count of the last byte, 8 if aligned).
// Operation code 3 is taken and dropped without a response.
// Responses leave on rsp_* (valid/ready) as rsp_out_byte; rsp_last marks the
// final byte caused by a request.
// One request is worked at a time. Path bits go through a bit-serial source,
// one bit per cycle unless a completed byte waits for a full response
// register. A byte completed by a path bit appears on rsp_* in the cycle
// after that bit.
// The response register holds one byte; while rsp_ready is low and that
// register is full, the work stops at the next byte to be sent and resumes
// when the byte is taken. req_ready is high only between requests.
// Reset clears the partial byte, sets the free count to eight and empties
// the response register.
// Depends on mbp_pkg, mbp_path_src and mbp_byte_acc.
module msb_first_bit_packer_core
   import mbp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [OpW-1:0]        req_operation,
   input  logic [PathFieldW-1:0] req_path_bits,
   input  logic [PathLenW-1:0]   req_path_len,
   input  logic [ByteW-1:0]      req_data_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [ByteW-1:0]      rsp_out_byte,
   output logic                  rsp_last
);

   state_type        state_ff;
   state_type        state_in;
   logic             out_valid_ff;
   logic [ByteW-1:0] out_byte_ff;
   logic             out_last_ff;
   logic [ByteW-1:0] data_ff;

   logic             accept;
   logic             can_emit;
   logic             emit;
   logic [ByteW-1:0] emit_byte;
   logic             emit_last;
   logic             step;
   logic             path_bit;
   logic [PathLenW-1:0] path_remaining;
   acc_cmd_type      cmd;
   acc_status_type   status;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign can_emit  = !out_valid_ff || rsp_ready;

   // Bit-serial path source.
   mbp_path_src u_path_src (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .path_bits (req_path_bits),
      .path_len  (req_path_len),
      .step      (step),
      .cur_bit   (path_bit),
      .remaining (path_remaining)
   );

   // Partial byte and alignment.
   mbp_byte_acc u_byte_acc (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .insert_data (data_ff),
      .status      (status)
   );

   // Insert byte is held for the duration of the request.
   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req_data_byte;
      end
   end

   // Sequencer: next state, accumulator commands and the byte to send.
   always_comb begin
      state_in     = state_ff;
      emit         = 1'b0;
      emit_byte    = '0;
      emit_last    = 1'b0;
      step         = 1'b0;
      cmd          = '0;
      cmd.bit_val  = path_bit;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (op_type'(req_operation))
                  OP_APPEND: state_in = ST_PATH;
                  OP_INSERT: state_in = ST_INSERT;
                  OP_FLUSH:  state_in = ST_FLUSH;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_PATH: begin
            if (path_remaining == '0) begin
               state_in = ST_IDLE;
            end else if (!status.one_free) begin
               cmd.push_bit = 1'b1;
               step         = 1'b1;
            end else if (can_emit) begin
               // This bit completes a byte; it is the last one if fewer
               // than a byte of bits follow.
               cmd.push_bit = 1'b1;
               step         = 1'b1;
               emit         = 1'b1;
               emit_byte    = status.full_byte;
               emit_last    = (path_remaining <= PathLenW'(ByteW));
            end
         end
         ST_INSERT: begin
            if (can_emit) begin
               cmd.insert = 1'b1;
               emit       = 1'b1;
               emit_byte  = status.insert_byte;
               emit_last  = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (can_emit) begin
               emit = 1'b1;
               if (!status.empty) begin
                  emit_byte = status.partial_byte;
                  state_in  = ST_TRAIL;
               end else begin
                  emit_byte = status.trailer_byte;
                  emit_last = 1'b1;
                  cmd.clear = 1'b1;
                  state_in  = ST_IDLE;
               end
            end
         end
         ST_TRAIL: begin
            if (can_emit) begin
               emit      = 1'b1;
               emit_byte = status.trailer_byte;
               emit_last = 1'b1;
               cmd.clear = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_byte_ff <= emit_byte;
         out_last_ff <= emit_last;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_last     = out_last_ff;

`ifndef ASSERT_OFF
   // A byte is only loaded when the response register is free or being drained.
   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      emit |-> (!out_valid_ff || rsp_ready))
      else $error("byte loaded over an untaken response");

   // An exhausted path never sends a byte.
   a_path_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PATH && path_remaining == '0) |-> !emit)
      else $error("byte sent after path ended");

   // The trailer always closes a request.
   a_trailer_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TRAIL && emit) |-> emit_last)
      else $error("trailer byte without last flag");

   // An accepted insert request goes straight to the insert step.
   a_insert_next: assert property (@(posedge clock) disable iff (reset)
      (accept && req_operation == OP_INSERT) |=> (state_ff == ST_INSERT))
      else $error("insert request not started");
`endif

endmodule

// ===== hw/rtl/mbp_path_src.sv =====
// Bit-serial source of path bits, highest index first, one bit per step.
// Depends on mbp_pkg.
module mbp_path_src
   import mbp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic [PathFieldW-1:0] path_bits,
   input  logic [PathLenW-1:0]   path_len,
   input  logic                  step,
   output logic                  cur_bit,
   output logic [PathLenW-1:0]   remaining
);

   logic [PathFieldW-1:0] bits_ff;
   logic [PathLenW-1:0]   cnt_ff;
   logic [PathLenW-1:0]   cnt_in;
   logic [PathLenW-1:0]   sat_len;
   logic [BitIdxW-1:0]    idx;

   // Clamp the length to the longest path supported.
   assign sat_len = (path_len > PathLenW'(PathLimit)) ? PathLenW'(PathLimit) : path_len;

   // The next bit to send sits at index remaining-1.
   assign idx       = cnt_ff[BitIdxW-1:0] - BitIdxW'(1);
   assign cur_bit   = bits_ff[idx];
   assign remaining = cnt_ff;

   // Count of bits still to send.
   always_comb begin
      cnt_in = cnt_ff;
      if (load) begin
         cnt_in = sat_len;
      end else if (step) begin
         cnt_in = cnt_ff - PathLenW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Path bits are held for the duration of the request.
   always_ff @(posedge clock) begin
      if (load) begin
         bits_ff <= path_bits;
      end
   end

endmodule

// ===== hw/rtl/mbp_byte_acc.sv =====
// Partial-byte accumulator: filled bits at the top, count of free positions.
// Depends on mbp_pkg.
module mbp_byte_acc
   import mbp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  acc_cmd_type      cmd,
   input  logic [ByteW-1:0] insert_data,
   output acc_status_type   status
);

   logic [ByteW-1:0] partial_ff;
   logic [ByteW-1:0] partial_in;
   logic [RoomW-1:0] room_ff;
   logic [RoomW-1:0] room_in;
   logic [ByteW-1:0] filled;
   logic [ByteW-1:0] merged;

   // Byte with the incoming bit placed at the highest free position.
   assign filled = partial_ff | (ByteW'(cmd.bit_val) << (room_ff - RoomW'(1)));

   // A whole byte placed at the current alignment: its top part completes a byte.
   assign merged = partial_ff | (insert_data >> (RoomW'(ByteW) - room_ff));

   assign status.partial_byte = partial_ff;
   assign status.full_byte    = filled;
   assign status.insert_byte  = merged;
   assign status.trailer_byte = (room_ff == RoomW'(ByteW)) ? ByteW'(ByteW)
                                : ByteW'(RoomW'(ByteW) - room_ff);
   assign status.empty        = (room_ff == RoomW'(ByteW));
   assign status.one_free     = (room_ff == RoomW'(1));

   // Next partial byte and free count.
   always_comb begin
      partial_in = partial_ff;
      room_in    = room_ff;
      if (cmd.clear) begin
         partial_in = '0;
         room_in    = RoomW'(ByteW);
      end else if (cmd.insert) begin
         partial_in = insert_data << room_ff;
      end else if (cmd.push_bit) begin
         if (room_ff == RoomW'(1)) begin
            partial_in = '0;
            room_in    = RoomW'(ByteW);
         end else begin
            partial_in = filled;
            room_in    = room_ff - RoomW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         room_ff    <= RoomW'(ByteW);
      end else begin
         partial_ff <= partial_in;
         room_ff    <= room_in;
      end
   end

endmodule
